// ----- hw/rtl/mmcs_pkg.sv -----
// Shared types and constants for the min/max contrast stretch block.
package mmcs_pkg;

  localparam int unsigned PixelWidth   = 8;
  localparam int unsigned QueueDepthDf = 2;

  localparam logic [PixelWidth-1:0] FullScale = 8'd255;
  localparam logic [PixelWidth-1:0] LowReset  = 8'd255;
  localparam logic [PixelWidth-1:0] HighReset = 8'd0;

  // How the back end has to produce the result of one apply-pass pixel.
  typedef enum logic [1:0] {
    KIND_FLAT,
    KIND_ZERO,
    KIND_FULL,
    KIND_DIV
  } mmcs_kind_e;

  typedef struct packed {
    mmcs_kind_e            kind;
    logic [PixelWidth-1:0] num;  // pixel minus stored minimum
    logic [PixelWidth-1:0] den;  // stored maximum minus stored minimum
  } mmcs_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } mmcs_state_e;

  typedef struct packed {
    logic [PixelWidth-1:0] low;
    logic [PixelWidth-1:0] high;
  } mmcs_levels_t;

endpackage

// ----- hw/rtl/mmcs_front.sv -----
// Front end: tracks the running minimum and maximum and classifies apply-pass pixels.
module mmcs_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             beat_i,
  input  logic [mmcs_pkg::PixelWidth-1:0]  pixel_i,
  input  logic                             apply_i,
  input  logic                             first_i,
  output logic                             push_o,
  output mmcs_pkg::mmcs_cmd_t              cmd_o,
  output mmcs_pkg::mmcs_levels_t           levels_o
);

  logic [mmcs_pkg::PixelWidth-1:0] low_q, low_d;
  logic [mmcs_pkg::PixelWidth-1:0] high_q, high_d;

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (beat_i && !apply_i) begin
      if (first_i) begin
        low_d  = pixel_i;
        high_d = pixel_i;
      end else begin
        if (pixel_i < low_q) begin
          low_d = pixel_i;
        end
        if (pixel_i > high_q) begin
          high_d = pixel_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= mmcs_pkg::LowReset;
      high_q <= mmcs_pkg::HighReset;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  // An inverted range, as left by reset, is handled like a flat image.
  always_comb begin
    cmd_o.num = pixel_i - low_q;
    cmd_o.den = high_q - low_q;
    if (high_q <= low_q) begin
      cmd_o.kind = mmcs_pkg::KIND_FLAT;
    end else if (pixel_i <= low_q) begin
      cmd_o.kind = mmcs_pkg::KIND_ZERO;
    end else if (pixel_i >= high_q) begin
      cmd_o.kind = mmcs_pkg::KIND_FULL;
    end else begin
      cmd_o.kind = mmcs_pkg::KIND_DIV;
    end
  end

  assign push_o        = beat_i && apply_i;
  assign levels_o.low  = low_q;
  assign levels_o.high = high_q;

endmodule

// ----- hw/rtl/mmcs_queue.sv -----
// Small command queue between the front end and the divider back end.
module mmcs_queue #(
  parameter int unsigned Depth = mmcs_pkg::QueueDepthDf
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mmcs_pkg::mmcs_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output mmcs_pkg::mmcs_cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mmcs_pkg::mmcs_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- hw/rtl/mmcs_back.sv -----
// Back end: restoring divider for 255*(p-min)/(max-min) and the output register.
module mmcs_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  mmcs_pkg::mmcs_cmd_t              cmd_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mmcs_pkg::PixelWidth-1:0]  out_data_o,
  output logic                             out_flat_o
);

  localparam int unsigned W    = mmcs_pkg::PixelWidth;
  localparam int unsigned CntW = $clog2(W);

  mmcs_pkg::mmcs_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    lo_q, lo_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    den_q, den_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_data_q, out_data_d;
  logic            out_flat_q, out_flat_d;

  logic [2*W-1:0]  numer;
  logic [W:0]      rem_shift;
  logic [W:0]      diff;
  logic            qbit;
  logic            out_free;

  // 255*n as (n << 8) - n; the quotient always fits in W bits since n < den.
  assign numer     = {cmd_i.num, {W{1'b0}}} - {{W{1'b0}}, cmd_i.num};
  assign rem_shift = {rem_q, lo_q[W-1]};
  assign diff      = rem_shift - {1'b0, den_q};
  assign qbit      = (rem_shift >= {1'b0, den_q});
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    quo_d       = quo_q;
    den_d       = den_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_flat_d  = out_flat_q;
    pop_o       = 1'b0;
    case (state_q)
      mmcs_pkg::ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            mmcs_pkg::KIND_FLAT: begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
              out_flat_d  = 1'b1;
            end
            mmcs_pkg::KIND_ZERO: begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
              out_flat_d  = 1'b0;
            end
            mmcs_pkg::KIND_FULL: begin
              out_valid_d = 1'b1;
              out_data_d  = mmcs_pkg::FullScale;
              out_flat_d  = 1'b0;
            end
            default: begin
              rem_d   = numer[2*W-1:W];
              lo_d    = numer[W-1:0];
              den_d   = cmd_i.den;
              quo_d   = '0;
              cnt_d   = '0;
              state_d = mmcs_pkg::ST_DIV;
            end
          endcase
        end
      end
      mmcs_pkg::ST_DIV: begin
        rem_d = qbit ? diff[W-1:0] : rem_shift[W-1:0];
        lo_d  = {lo_q[W-2:0], 1'b0};
        quo_d = {quo_q[W-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        // The output register was free when the division started and nothing else fills it.
        if (cnt_q == CntW'(W - 1)) begin
          out_valid_d = 1'b1;
          out_data_d  = {quo_q[W-2:0], qbit};
          out_flat_d  = 1'b0;
          state_d     = mmcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mmcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmcs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    lo_q       <= lo_d;
    quo_q      <= quo_d;
    den_q      <= den_d;
    out_data_q <= out_data_d;
    out_flat_q <= out_flat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_flat_o  = out_flat_q;

endmodule

// ----- hw/rtl/min_max_contrast_stretch_top.sv -----
// Top level of the two-pass min/max contrast stretch block.
//
// The image is streamed in twice on the slave channel, one pixel per beat.
// tuser[0] (apply) is 0 in the measure pass: the beat folds the pixel into
// the running minimum and maximum, tuser[1] (first) restarting both, and no
// result beat follows. In the apply pass each beat yields one result beat on
// the master channel: 255*(p-min)/(max-min), floored and saturated, or 0 with
// the flat flag when the stored range is empty.
// Measure beats are taken one per cycle while the queue is not full. An apply
// beat enters a small queue; the back end turns pixels at or beyond the stored
// range, and flat images, into a result in the output register, one per cycle
// while that register is free. A pixel strictly inside the range goes through
// the radix-2 restoring divider, one quotient bit a cycle; the back end takes
// no new pixel from the queue until that division has finished.
// The result sits in an output register; while the receiver stalls, the
// queue still fills, and tready drops only once it is full.
// Reset sets the minimum to 255 and the maximum to 0 and empties the queue.
module min_max_contrast_stretch_top #(
  parameter int unsigned QueueDepth = mmcs_pkg::QueueDepthDf
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel
  input  logic [1:0] s_axis_tuser,   // [0] apply, [1] first
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] stretched
  output logic [0:0] m_axis_tuser    // [0] flat
);

  logic                   beat;
  logic                   push;
  logic                   full;
  logic                   pop;
  logic                   cmd_valid;
  mmcs_pkg::mmcs_cmd_t    push_cmd;
  mmcs_pkg::mmcs_cmd_t    pop_cmd;
  mmcs_pkg::mmcs_levels_t levels;
  logic                   out_flat;

  assign s_axis_tready = !full;
  assign beat          = s_axis_tvalid && s_axis_tready;

  mmcs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat),
    .pixel_i  (s_axis_tdata),
    .apply_i  (s_axis_tuser[0]),
    .first_i  (s_axis_tuser[1]),
    .push_o   (push),
    .cmd_o    (push_cmd),
    .levels_o (levels)
  );

  mmcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (cmd_valid),
    .pop_cmd_o  (pop_cmd)
  );

  mmcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_flat_o  (out_flat)
  );

  assign m_axis_tuser[0] = out_flat;

  a_flat_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("flat result with a nonzero pixel");

  a_first_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !s_axis_tuser[0] && s_axis_tuser[1]) |=>
    (levels.low == $past(s_axis_tdata) && levels.high == $past(s_axis_tdata)))
    else $error("first pixel did not restart the levels");

  a_levels_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !s_axis_tuser[0]) |=> (levels.low <= levels.high))
    else $error("minimum above maximum after a measure beat");

endmodule

// ----- test/tb_min_max_contrast_stretch_top.sv -----
// Self-checking testbench for the min/max contrast stretch block.
`timescale 1ns / 1ps

module tb_min_max_contrast_stretch_top;

  localparam int unsigned RandomBeats   = 800;
  localparam int unsigned SqueezeCycles = 120;
  localparam int unsigned TailCycles    = 16;
  localparam int unsigned NumRows       = 24;

  // One directed beat; when known is set, the expected result is typed in.
  typedef struct packed {
    logic [7:0] pixel;
    logic       apply;
    logic       first;
    logic       known;
    logic [7:0] stretched;
    logic       flat;
  } stim_row_t;

  typedef struct packed {
    logic [mmcs_pkg::PixelWidth-1:0] stretched;
    logic                            flat;
  } stretch_res_t;

  localparam stim_row_t DirectedRows [NumRows] = '{
    '{8'd0,   1'b1, 1'b0, 1'b1, 8'd0,   1'b1},
    '{8'd255, 1'b1, 1'b1, 1'b1, 8'd0,   1'b1},
    '{8'd100, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd100, 1'b1, 1'b0, 1'b1, 8'd0,   1'b1},
    '{8'd50,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd200, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b1, 1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd50,  1'b1, 1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd255, 1'b1, 1'b0, 1'b1, 8'd255, 1'b0},
    '{8'd200, 1'b1, 1'b0, 1'b1, 8'd255, 1'b0},
    '{8'd125, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd51,  1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd199, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd255, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b1, 1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd255, 1'b1, 1'b0, 1'b1, 8'd255, 1'b0},
    '{8'd1,   1'b1, 1'b0, 1'b1, 8'd1,   1'b0},
    '{8'd254, 1'b1, 1'b0, 1'b1, 8'd254, 1'b0},
    '{8'd170, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd7,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd7,   1'b1, 1'b0, 1'b1, 8'd0,   1'b1},
    '{8'd9,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd8,   1'b1, 1'b0, 1'b0, 8'd0,   1'b0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] pixel
  logic [1:0] s_axis_tuser;   // [0] apply, [1] first
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] stretched
  logic [0:0] m_axis_tuser;   // [0] flat

  // Typed-in expectation that travels alongside the current input beat.
  logic       beat_known;
  logic [7:0] beat_stretched;
  logic       beat_flat;

  logic [mmcs_pkg::PixelWidth-1:0] seen_min;
  logic [mmcs_pkg::PixelWidth-1:0] seen_max;
  stretch_res_t                    pending_results [$];
  stretch_res_t                    predicted;
  stretch_res_t                    wanted;

  logic        steady_phase = 1'b0;
  logic        squeeze_req  = 1'b0;
  logic        squeeze_done = 1'b0;
  int unsigned fail_count   = 0;
  int unsigned beats_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned flat_seen    = 0;

  min_max_contrast_stretch_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Updates the running levels and, for an apply beat, returns the result.
  function automatic logic predict_pixel(input logic [mmcs_pkg::PixelWidth-1:0] pixel,
                                         input logic apply, input logic first,
                                         output stretch_res_t res);
    logic [2*mmcs_pkg::PixelWidth-1:0] scaled;
    res = '0;
    if (!apply) begin
      if (first) begin
        seen_min = pixel;
        seen_max = pixel;
      end else begin
        if (pixel < seen_min) seen_min = pixel;
        if (pixel > seen_max) seen_max = pixel;
      end
      return 1'b0;
    end
    // An empty or inverted range never divides.
    if (seen_max <= seen_min) begin
      res.flat = 1'b1;
    end else if (pixel <= seen_min) begin
      res.stretched = '0;
    end else if (pixel >= seen_max) begin
      res.stretched = mmcs_pkg::FullScale;
    end else begin
      scaled = (16'(mmcs_pkg::FullScale) * 16'(pixel - seen_min))
               / 16'(seen_max - seen_min);
      res.stretched = scaled[mmcs_pkg::PixelWidth-1:0];
    end
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_phase || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_pixel(input logic [7:0] pixel, input logic apply, input logic first,
                             input logic known, input logic [7:0] stretched,
                             input logic flat);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid  <= 1'b1;
    s_axis_tdata   <= pixel;
    s_axis_tuser   <= {first, apply};
    beat_known     <= known;
    beat_stretched <= stretched;
    beat_flat      <= flat;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Predicts on every accepted input beat, then checks every accepted result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_min = mmcs_pkg::LowReset;
      seen_max = mmcs_pkg::HighReset;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_pixel(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1], predicted)) begin
          if (beat_known) begin
            predicted.stretched = beat_stretched;
            predicted.flat      = beat_flat;
          end
          pending_results = {pending_results, predicted};
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result beat with no pixel pending: stretched=%0d flat=%0b",
                 m_axis_tdata, m_axis_tuser[0]);
          fail_count++;
        end else begin
          wanted = pending_results.pop_front();
          if (wanted.flat) flat_seen++;
          if (m_axis_tdata !== wanted.stretched) begin
            $error("stretched: expected %0d, got %0d", wanted.stretched, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[0] !== wanted.flat) begin
            $error("flat: expected %0b, got %0b", wanted.flat, m_axis_tuser[0]);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the input side backs up.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        m_axis_tready <= 1'b0;
        repeat (SqueezeCycles) @(posedge clk_i);
        squeeze_done = 1'b1;
      end else if (steady_phase) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [7:0]  frame_pix [16];
    int unsigned n_pix;
    int unsigned lo;
    int unsigned span;
    int unsigned kind;
    logic        restart;
    logic        stray;

    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= '0;
    beat_known     <= 1'b0;
    beat_stretched <= '0;
    beat_flat      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      offer_pixel(DirectedRows[i].pixel, DirectedRows[i].apply, DirectedRows[i].first,
                  DirectedRows[i].known, DirectedRows[i].stretched, DirectedRows[i].flat);
    end

    while (beats_sent < NumRows + RandomBeats) begin
      steady_phase = ($urandom_range(0, 4) == 0);
      if (!squeeze_req && beats_sent >= 300) squeeze_req = 1'b1;
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        // A whole image: measure pass, then apply pass over the same pixels or, at times, random ones.
        n_pix = $urandom_range(1, 12);
        lo    = $urandom_range(0, 255);
        case ($urandom_range(0, 9))
          0: span = 0;
          1: begin
            lo   = 0;
            span = 255;
          end
          default: span = $urandom_range(0, 255 - lo);
        endcase
        for (int i = 0; i < n_pix; i++) frame_pix[i] = 8'(lo + $urandom_range(0, span));
        frame_pix[0]       = 8'(lo);
        frame_pix[n_pix-1] = 8'(lo + span);
        restart = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < n_pix; i++) begin
          offer_pixel(frame_pix[i], 1'b0, restart && (i == 0), 1'b0, '0, 1'b0);
        end
        stray = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n_pix; i++) begin
          offer_pixel(stray ? 8'($urandom_range(0, 255)) : frame_pix[i], 1'b1,
                      ($urandom_range(0, 7) == 0), 1'b0, '0, 1'b0);
        end
        frames_sent++;
      end else if (kind < 17) begin
        // Measure beats without a restart keep widening the current range.
        repeat ($urandom_range(1, 4)) begin
          offer_pixel(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0, 1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          offer_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    steady_phase = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d pixel beats: %0d directed, the rest random with %0d two-pass images.",
             beats_sent, NumRows, frames_sent);
    $display("Checked %0d result beats, %0d with an empty range.", results_seen, flat_seen);
    if (fail_count == 0) begin
      $display("tb_min_max_contrast_stretch_top OK");
    end else begin
      $display("tb_min_max_contrast_stretch_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_min_max_contrast_stretch_top NOT OK");
    $finish;
  end

endmodule
